// ----- rtl/sqltok_pkg.sv -----
package sqltok_pkg;

  localparam int OFFSET_BITS_DEF = 32;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int KW_CHARS        = 6;
  localparam int KW_NUM          = 8;
  localparam int PUNCT_NUM       = 6;
  localparam int FIFO_DEPTH      = 4;

  localparam logic [4:0] KIND_LPAREN  = 5'd0;
  localparam logic [4:0] KIND_STRING  = 5'd6;
  localparam logic [4:0] KIND_NUMBER  = 5'd7;
  localparam logic [4:0] KIND_IDENT   = 5'd8;
  localparam logic [4:0] KIND_CREATE  = 5'd9;
  localparam logic [4:0] KIND_UNKNOWN = 5'd17;
  localparam logic [4:0] KIND_END     = 5'd18;

  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_SQUOTE     = 8'h27;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  typedef logic [0:KW_CHARS-1][7:0] kw_text_t;

  // punctuation kinds follow table order
  localparam logic [7:0] PUNCT_CHARS [PUNCT_NUM] = '{8'h28, 8'h29, 8'h2C, 8'h3B, 8'h2A, 8'h3D};

  localparam kw_text_t KW_TEXT [KW_NUM] = '{
    kw_text_t'("CREATE"),
    kw_text_t'({"TABLE", 8'h00}),
    kw_text_t'("INSERT"),
    kw_text_t'({"INTO", 16'h0000}),
    kw_text_t'("VALUES"),
    kw_text_t'("SELECT"),
    kw_text_t'({"FROM", 16'h0000}),
    kw_text_t'({"WHERE", 8'h00})
  };
  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd6, 3'd5, 3'd6, 3'd4, 3'd6, 3'd6, 3'd4, 3'd5};

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_mark;
  } tok_in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic [7:0]  char_value;
    logic        last_of_item;
  } tok_out_t;

  function automatic logic [4:0] kw_kind(kw_text_t chars, logic [2:0] count);
    logic [4:0] kind;
    logic       hit;
    kind = KIND_IDENT;
    for (int i = KW_NUM - 1; i >= 0; i--) begin
      hit = (count == KW_LEN[i]);
      for (int j = 0; j < KW_CHARS; j++) begin
        if ((3'(j) < KW_LEN[i]) && (chars[j] != KW_TEXT[i][j])) hit = 1'b0;
      end
      if (hit) kind = KIND_CREATE + 5'(i);
    end
    return kind;
  endfunction

endpackage

// ----- rtl/sql_keyword_tokenizer.sv -----
// Streaming SQL tokenizer. One text byte (or a closing end beat) is taken per clock while in_stall
// is low; each beat yields zero, one or two token descriptors, which are queued in a 4-entry
// output FIFO whose head entry drives out_data. in_stall rises whenever fewer than two FIFO
// slots are free, so the sustained rate is one input beat per clock as long as the consumer
// keeps up and no beat yields two descriptors; a beat that closes a token and also emits a
// single-character or end token writes two FIFO entries. Offsets and lengths saturate
// at OFFSET_BITS and LENGTH_BITS, and the end beat returns the offset count to zero.
module sql_keyword_tokenizer #(
  parameter int OFFSET_BITS = sqltok_pkg::OFFSET_BITS_DEF,
  parameter int LENGTH_BITS = sqltok_pkg::LENGTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sqltok_pkg::tok_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sqltok_pkg::tok_out_t out_data
);
  import sqltok_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_STRING = 4'b0010,
    MODE_NUMBER = 4'b0100,
    MODE_IDENT  = 4'b1000
  } scan_mode_t;

  scan_mode_t             mode_r, mode_nxt;
  logic                   qdq_r, qdq_nxt;
  logic [OFFSET_BITS-1:0] tok_start_r, tok_start_nxt;
  logic [LENGTH_BITS-1:0] tok_cnt_r, tok_cnt_nxt;
  kw_text_t               kw_chars_r, kw_chars_nxt;
  logic [OFFSET_BITS-1:0] byte_pos_r, byte_pos_nxt;

  tok_out_t               fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]       fill_r, fill_nxt;

  logic                   in_acc, out_acc;
  logic [7:0]             c;
  logic [7:0]             c_up;
  logic                   is_digit, is_alpha, is_space, is_word;
  logic                   p_hit;
  logic [4:0]             p_kind;
  logic                   pos_sat, cnt_sat;
  logic [LENGTH_BITS-1:0] cnt_inc;
  logic                   flush_now, emit_now, taken;
  tok_out_t               flush_res, emit_res, res0, res1;
  logic [1:0]             n_res;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  assign c        = in_data.char_byte;
  assign is_digit = (c >= "0") && (c <= "9");
  assign is_alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  assign is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign is_word  = is_alpha || is_digit || (c == CH_UNDERSCORE);
  assign c_up     = ((c >= "a") && (c <= "z")) ? c - CASE_OFFSET : c;

  assign pos_sat = (byte_pos_r == {OFFSET_BITS{1'b1}});
  assign cnt_sat = (tok_cnt_r == {LENGTH_BITS{1'b1}});
  assign cnt_inc = cnt_sat ? tok_cnt_r : tok_cnt_r + 1'b1;

  always_comb begin
    p_hit  = 1'b0;
    p_kind = KIND_LPAREN;
    for (int i = 0; i < PUNCT_NUM; i++) begin
      if (c == PUNCT_CHARS[i]) begin
        p_hit  = 1'b1;
        p_kind = KIND_LPAREN + 5'(i);
      end
    end
  end

  // pending token descriptor
  always_comb begin
    flush_res              = '0;
    flush_res.start_offset = 32'(tok_start_r);
    flush_res.token_length = 16'(tok_cnt_r);
    case (mode_r)
      MODE_STRING: flush_res.token_kind = KIND_STRING;
      MODE_NUMBER: flush_res.token_kind = KIND_NUMBER;
      MODE_IDENT: begin
        if (tok_cnt_r <= LENGTH_BITS'(KW_CHARS)) begin
          flush_res.token_kind = kw_kind(kw_chars_r, tok_cnt_r[2:0]);
        end else begin
          flush_res.token_kind = KIND_IDENT;
        end
      end
      default: flush_res.token_kind = KIND_IDENT;
    endcase
  end

  always_comb begin
    mode_nxt      = mode_r;
    qdq_nxt       = qdq_r;
    tok_start_nxt = tok_start_r;
    tok_cnt_nxt   = tok_cnt_r;
    kw_chars_nxt  = kw_chars_r;
    byte_pos_nxt  = pos_sat ? byte_pos_r : byte_pos_r + 1'b1;
    flush_now     = 1'b0;
    emit_now      = 1'b0;
    taken         = 1'b0;
    emit_res              = '0;
    emit_res.start_offset = 32'(byte_pos_r);
    emit_res.token_length = 16'd1;
    emit_res.char_value   = c;
    emit_res.token_kind   = KIND_UNKNOWN;

    if (in_data.end_mark) begin
      flush_now             = (mode_r != MODE_IDLE);
      emit_now              = 1'b1;
      emit_res.token_kind   = KIND_END;
      emit_res.token_length = '0;
      emit_res.char_value   = '0;
      mode_nxt      = MODE_IDLE;
      qdq_nxt       = 1'b0;
      tok_start_nxt = '0;
      tok_cnt_nxt   = '0;
      byte_pos_nxt  = '0;
    end else begin
      case (mode_r)
        MODE_STRING: begin
          taken = 1'b1;
          if (c == (qdq_r ? CH_DQUOTE : CH_SQUOTE)) begin
            flush_now = 1'b1;
            mode_nxt  = MODE_IDLE;
          end else begin
            tok_cnt_nxt = cnt_inc;
          end
        end
        MODE_NUMBER: begin
          if (is_digit || (c == CH_DOT)) begin
            taken       = 1'b1;
            tok_cnt_nxt = cnt_inc;
          end else begin
            flush_now = 1'b1;
            mode_nxt  = MODE_IDLE;
          end
        end
        MODE_IDENT: begin
          if (is_word) begin
            taken = 1'b1;
            if (tok_cnt_r < LENGTH_BITS'(KW_CHARS)) kw_chars_nxt[tok_cnt_r[2:0]] = c_up;
            tok_cnt_nxt = cnt_inc;
          end else begin
            flush_now = 1'b1;
            mode_nxt  = MODE_IDLE;
          end
        end
        default: taken = 1'b0;
      endcase

      if (!taken && !is_space) begin
        if (p_hit) begin
          emit_now            = 1'b1;
          emit_res.token_kind = p_kind;
        end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
          mode_nxt      = MODE_STRING;
          qdq_nxt       = (c == CH_DQUOTE);
          tok_start_nxt = pos_sat ? byte_pos_r : byte_pos_r + 1'b1;
          tok_cnt_nxt   = '0;
        end else if (is_digit) begin
          mode_nxt      = MODE_NUMBER;
          tok_start_nxt = byte_pos_r;
          tok_cnt_nxt   = LENGTH_BITS'(1);
        end else if (is_alpha || (c == CH_UNDERSCORE)) begin
          mode_nxt        = MODE_IDENT;
          tok_start_nxt   = byte_pos_r;
          tok_cnt_nxt     = LENGTH_BITS'(1);
          kw_chars_nxt[0] = c_up;
        end else begin
          emit_now = 1'b1;
        end
      end
    end
  end

  // result ordering: pending token first, then the single-byte or end token
  always_comb begin
    res0 = flush_now ? flush_res : emit_res;
    res1 = emit_res;
    res0.last_of_item = !(flush_now && emit_now);
    res1.last_of_item = 1'b1;
    n_res = {1'b0, flush_now} + {1'b0, emit_now};
  end

  always_comb begin
    fill_nxt = fill_r;
    if (in_acc) fill_nxt = fill_nxt + CNT_W'(n_res);
    if (out_acc) fill_nxt = fill_nxt - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      qdq_r       <= 1'b0;
      tok_start_r <= '0;
      tok_cnt_r   <= '0;
      byte_pos_r  <= '0;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      fill_r      <= '0;
    end else begin
      if (in_acc) begin
        mode_r      <= mode_nxt;
        qdq_r       <= qdq_nxt;
        tok_start_r <= tok_start_nxt;
        tok_cnt_r   <= tok_cnt_nxt;
        byte_pos_r  <= byte_pos_nxt;
        wr_ptr_r    <= wr_ptr_r + PTR_W'(n_res);
      end
      if (out_acc) rd_ptr_r <= rd_ptr_r + 1'b1;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kw_chars_r <= kw_chars_nxt;
      if (n_res != 2'd0) fifo_r[wr_ptr_r] <= res0;
      if (n_res == 2'd2) fifo_r[PTR_W'(wr_ptr_r + 1'b1)] <= res1;
    end
  end

  assign in_stall  = (fill_r > CNT_W'(FIFO_DEPTH - 2));
  assign out_valid = (fill_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(FIFO_DEPTH))
    else $error("output fifo overfilled");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.end_mark |=> (mode_r == MODE_IDLE) && (byte_pos_r == '0))
    else $error("end beat did not clear scan state");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == KIND_END) |-> out_data.last_of_item)
    else $error("end token without last flag");

  a_two_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (n_res == 2'd2) |=> (fill_r >= 2'd2))
    else $error("two-result beat lost an entry");
`endif

endmodule
